/* src/ubrc_pkg.sv */
// Shared types, codes and the CRC-CCITT byte update for the upload block receive checker.
package ubrc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int POS_W  = 11;
  localparam int KIND_W = 2;
  localparam int VERD_W = 2;

  localparam int MAX_DATA_BYTES_DEF = 1024;

  localparam logic [BYTE_W-1:0] START_BLOCK_RESET = 8'd1;
  localparam logic [CRC_W-1:0]  CRC_POLY          = 16'h1021;
  localparam logic [POS_W-1:0]  POS_LIMIT         = 11'd2047;
  localparam logic [POS_W-1:0]  POS_NUMBER        = 11'd1;
  localparam logic [POS_W-1:0]  POS_COMPLEMENT    = 11'd2;
  localparam logic [POS_W-1:0]  POS_FIRST_DATA    = 11'd4;
  localparam logic [POS_W-1:0]  POS_FIRST_CRC_IN  = 11'd5;
  localparam logic [BYTE_W:0]   COMPLEMENT_SUM    = 9'h0FF;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd2;

  // block verdicts
  localparam logic [VERD_W-1:0] VERD_ACCEPT    = 2'd0;
  localparam logic [VERD_W-1:0] VERD_DUPLICATE = 2'd1;
  localparam logic [VERD_W-1:0] VERD_REJECT    = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              last_byte;
  } item_t;

  // CRC-CCITT, MSB first, one byte unrolled over eight bit steps
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/upload_block_receive_checker_core.sv */
// Top level of the upload block receive checker.
// Checks one upload block frame fed a byte per word: header, block number, its complement,
// payload, then the CRC-CCITT (init 0, MSB first) low byte first, with last_byte on the
// final byte. Every accepted word gives exactly one result word: nothing, a payload byte
// (emitted one byte late so the CRC bytes are never passed on), or the block verdict with
// the frame's block number and payload length. The block takes one byte per clock cycle
// while the result is not stalled, and each result is registered: the byte sits in the
// input register while the CRC and verdict logic feeds the result register; the CRC byte
// update is fully unrolled in combinational logic. A stalled result holds both registers,
// so the input stalls once both are full. Writing start_block reloads the
// expected block number (reset value 1); an accepted block advances it, wrapping at 255.
module upload_block_receive_checker_core #(
  parameter int MAX_DATA_BYTES = ubrc_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ubrc_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ubrc_pkg::KIND_W-1:0] out_kind,
  output logic [ubrc_pkg::BYTE_W-1:0] payload_byte,
  output logic [ubrc_pkg::VERD_W-1:0] verdict,
  output logic [ubrc_pkg::BYTE_W-1:0] block_number,
  output logic [ubrc_pkg::POS_W-1:0]  data_length,
  input  logic                        start_block_we,
  input  logic [ubrc_pkg::BYTE_W-1:0] start_block
);
  import ubrc_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  advance;

  assign in_item.rx_byte   = rx_byte;
  assign in_item.last_byte = last_byte;

  ubrc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ubrc_frame_core #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_frame_core (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .advance        (advance),
    .start_block_we (start_block_we),
    .start_block    (start_block),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .payload_byte   (payload_byte),
    .verdict        (verdict),
    .block_number   (block_number),
    .data_length    (data_length)
  );

`ifndef NO_ASSERTIONS
  a_new_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted byte two cycles earlier");

  a_payload_only_when_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (payload_byte == '0))
    else $error("payload byte nonzero on a non-payload result");

  a_verdict_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_VERDICT)
      |-> (verdict == VERD_ACCEPT && block_number == '0 && data_length == '0))
    else $error("verdict fields nonzero on a non-verdict result");

  a_accept_within_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_VERDICT && verdict == VERD_ACCEPT)
      |-> (32'(data_length) <= 32'(MAX_DATA_BYTES)))
    else $error("oversize block accepted");
`endif

endmodule

/* src/ubrc_in_stage.sv */
// Input register of the checker: captures one word per cycle while not stalled and drives the input stall.
module ubrc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ubrc_pkg::item_t in_item,
  input  logic           advance,
  output logic           s1_valid,
  output ubrc_pkg::item_t s1_item
);
  import ubrc_pkg::*;

  // hold only while the stored word cannot move on
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

endmodule

/* src/ubrc_frame_core.sv */
// Frame state, CRC and verdict logic with the result register of the checker.
module ubrc_frame_core #(
  parameter int MAX_DATA_BYTES = ubrc_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s1_valid,
  input  ubrc_pkg::item_t             s1_item,
  output logic                        advance,
  input  logic                        start_block_we,
  input  logic [ubrc_pkg::BYTE_W-1:0] start_block,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ubrc_pkg::KIND_W-1:0] out_kind,
  output logic [ubrc_pkg::BYTE_W-1:0] payload_byte,
  output logic [ubrc_pkg::VERD_W-1:0] verdict,
  output logic [ubrc_pkg::BYTE_W-1:0] block_number,
  output logic [ubrc_pkg::POS_W-1:0]  data_length
);
  import ubrc_pkg::*;

  localparam int MAX_W = $clog2(MAX_DATA_BYTES + 1);
  localparam int CMP_W = (MAX_W > POS_W) ? MAX_W : POS_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_DATA_BYTES);

  logic [BYTE_W-1:0] expected_block, expected_block_next;
  logic [CRC_W-1:0]  crc_accum, crc_accum_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] hold_older, hold_older_next;
  logic [BYTE_W-1:0] hold_newer, hold_newer_next;
  logic [BYTE_W-1:0] number_byte, number_byte_next;
  logic [BYTE_W-1:0] complement_byte, complement_byte_next;
  logic              oversize_flag, oversize_flag_next;

  logic [KIND_W-1:0] kind_next;
  logic [BYTE_W-1:0] payload_next;
  logic [VERD_W-1:0] verdict_next;
  logic [BYTE_W-1:0] number_out_next;
  logic [POS_W-1:0]  length_next;

  logic [CRC_W-1:0]  crc_cur;
  logic [POS_W-1:0]  data_idx;
  logic [POS_W-1:0]  pos_inc;
  logic              past_header;
  logic              over;
  logic              complement_bad;
  logic              is_duplicate;

  assign advance = s1_valid && (!out_valid || !out_stall);

  always_comb begin
    past_header = (byte_position >= POS_FIRST_DATA);
    data_idx    = past_header ? (byte_position - POS_FIRST_DATA) : '0;
    crc_cur     = (byte_position >= POS_FIRST_CRC_IN) ? crc_update(crc_accum, hold_older)
                                                       : crc_accum;

    expected_block_next  = expected_block;
    crc_accum_next       = crc_cur;
    byte_position_next   = byte_position;
    hold_older_next      = hold_newer;
    hold_newer_next      = s1_item.rx_byte;
    number_byte_next     = (byte_position == POS_NUMBER) ? s1_item.rx_byte : number_byte;
    complement_byte_next = (byte_position == POS_COMPLEMENT) ? s1_item.rx_byte
                                                             : complement_byte;
    oversize_flag_next   = oversize_flag;

    kind_next       = KIND_NONE;
    payload_next    = '0;
    verdict_next    = VERD_ACCEPT;
    number_out_next = '0;
    length_next     = '0;

    over = oversize_flag || (CMP_W'(data_idx) > MAX_LEN);
    complement_bad = (({1'b0, number_byte_next} + {1'b0, complement_byte_next})
                      != COMPLEMENT_SUM);
    is_duplicate = (expected_block != '0) && (number_byte_next == expected_block - 8'd1);
    pos_inc = (byte_position < POS_LIMIT) ? byte_position + 11'd1 : byte_position;

    if (s1_item.last_byte) begin
      if (!past_header || complement_bad) begin
        verdict_next = VERD_REJECT;
      end else if (number_byte_next != expected_block) begin
        verdict_next = is_duplicate ? VERD_DUPLICATE : VERD_REJECT;
      end else if (over) begin
        verdict_next = VERD_REJECT;
      end else if ({s1_item.rx_byte, hold_newer} != crc_cur) begin
        verdict_next = VERD_REJECT;
      end else begin
        verdict_next        = VERD_ACCEPT;
        expected_block_next = expected_block + 8'd1;
      end
      kind_next       = KIND_VERDICT;
      number_out_next = number_byte_next;
      length_next     = data_idx;
      // drop the frame state for the next block
      crc_accum_next       = '0;
      byte_position_next   = '0;
      hold_older_next      = '0;
      hold_newer_next      = '0;
      number_byte_next     = '0;
      complement_byte_next = '0;
      oversize_flag_next   = 1'b0;
    end else begin
      if (past_header) begin
        if (CMP_W'(data_idx) < MAX_LEN) begin
          kind_next    = KIND_PAYLOAD;
          payload_next = hold_newer;
        end else begin
          oversize_flag_next = 1'b1;
        end
      end
      byte_position_next = pos_inc;
      if (pos_inc >= POS_LIMIT) begin
        oversize_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_block  <= START_BLOCK_RESET;
      crc_accum       <= '0;
      byte_position   <= '0;
      hold_older      <= '0;
      hold_newer      <= '0;
      number_byte     <= '0;
      complement_byte <= '0;
      oversize_flag   <= 1'b0;
    end else begin
      if (advance) begin
        expected_block  <= expected_block_next;
        crc_accum       <= crc_accum_next;
        byte_position   <= byte_position_next;
        hold_older      <= hold_older_next;
        hold_newer      <= hold_newer_next;
        number_byte     <= number_byte_next;
        complement_byte <= complement_byte_next;
        oversize_flag   <= oversize_flag_next;
      end
      if (start_block_we) begin
        expected_block <= start_block;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind     <= kind_next;
      payload_byte <= payload_next;
      verdict      <= verdict_next;
      block_number <= number_out_next;
      data_length  <= length_next;
    end
  end

endmodule

/* tb/tb_upload_block_receive_checker_core.sv */
// Self-checking testbench for the upload block receive checker: directed frames, then random frames.
module tb_upload_block_receive_checker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ubrc_pkg::*;

  localparam int PERIOD       = 8;
  localparam int MAX_DATA     = MAX_DATA_BYTES_DEF;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] pay;
    logic [VERD_W-1:0] verd;
    logic [BYTE_W-1:0] num;
    logic [POS_W-1:0]  len;
  } res_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              l;
    res_t              r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [VERD_W-1:0] verdict;
  logic [BYTE_W-1:0] block_number;
  logic [POS_W-1:0]  data_length;
  logic start_block_we = 1'b0;
  logic [BYTE_W-1:0] start_block = START_BLOCK_RESET;

  // predictor state
  logic [BYTE_W-1:0] next_block;
  logic [CRC_W-1:0]  crc_run;
  logic [POS_W-1:0]  frame_pos;
  logic [BYTE_W-1:0] lag2;
  logic [BYTE_W-1:0] lag1;
  logic [BYTE_W-1:0] frame_number;
  logic [BYTE_W-1:0] frame_complement;
  logic              too_long;

  res_t pending_results[$];
  int   errors = 0;
  int   words_sent = 0;
  int   cycles = 0;
  bit   idle_on = 1'b0;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   stall_left = 0;

  always #(PERIOD / 2) clk = ~clk;

  upload_block_receive_checker_core #(
    .MAX_DATA_BYTES(MAX_DATA)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .payload_byte  (payload_byte),
    .verdict       (verdict),
    .block_number  (block_number),
    .data_length   (data_length),
    .start_block_we(start_block_we),
    .start_block   (start_block)
  );

  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] r;
    logic fb;
    r = c;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      fb = r[CRC_W-1] ^ d[k];
      r = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    crc_run = '0;
    frame_pos = '0;
    lag2 = '0;
    lag1 = '0;
    frame_number = '0;
    frame_complement = '0;
    too_long = 1'b0;
  endfunction

  // Advance the predicted checker by one word and return the result word it gives.
  function automatic res_t checker_step(input logic [BYTE_W-1:0] rx, input logic last);
    res_t r;
    int unsigned p;
    int unsigned len;
    logic [CRC_W-1:0] sent_crc;
    r = '0;
    p = frame_pos;
    if (p >= 5) begin
      crc_run = crc16_byte(crc_run, lag2);
    end
    if (p == 1) begin
      frame_number = rx;
    end else if (p == 2) begin
      frame_complement = rx;
    end
    if (last) begin
      len = (p >= 4) ? p - 4 : 0;
      sent_crc = {rx, lag1};
      r.kind = KIND_VERDICT;
      r.num = frame_number;
      r.len = len[POS_W-1:0];
      if (p < 4) begin
        r.verd = VERD_REJECT;
      end else if ({1'b0, frame_number} + {1'b0, frame_complement} != COMPLEMENT_SUM) begin
        r.verd = VERD_REJECT;
      end else if (frame_number != next_block) begin
        if (next_block != 0 && frame_number == next_block - 8'd1) begin
          r.verd = VERD_DUPLICATE;
        end else begin
          r.verd = VERD_REJECT;
        end
      end else if (too_long || len > MAX_DATA) begin
        r.verd = VERD_REJECT;
      end else if (sent_crc != crc_run) begin
        r.verd = VERD_REJECT;
      end else begin
        r.verd = VERD_ACCEPT;
        next_block = next_block + 8'd1;
      end
      clear_frame_state();
      return r;
    end
    if (p >= 4) begin
      if (p - 4 < MAX_DATA) begin
        r.kind = KIND_PAYLOAD;
        r.pay = lag1;
      end else begin
        too_long = 1'b1;
      end
    end
    lag2 = lag1;
    lag1 = rx;
    if (p < POS_LIMIT) begin
      frame_pos = POS_W'(p + 1);
    end
    if (frame_pos >= POS_LIMIT) begin
      too_long = 1'b1;
    end
    return r;
  endfunction

  function automatic row_t mk_row(input logic [BYTE_W-1:0] b, input logic l,
                                  input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] pay,
                                  input logic [VERD_W-1:0] verd, input logic [BYTE_W-1:0] num,
                                  input logic [POS_W-1:0] len);
    row_t w;
    w.b = b;
    w.l = l;
    w.r = '{kind: kind, pay: pay, verd: verd, num: num, len: len};
    return w;
  endfunction

  // Offer one word, hold it until taken, then queue what it should produce.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic l,
                           input bit typed, input res_t typed_res);
    res_t predicted;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    last_byte <= l;
    do @(negedge clk); while (in_stall);
    predicted = checker_step(b, l);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    @(posedge clk);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] num, input logic [BYTE_W-1:0] cmp,
                            input int plen, input bit bad_crc);
    logic [CRC_W-1:0] crc;
    logic [BYTE_W-1:0] d;
    crc = '0;
    send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    send_word(num, 1'b0, 1'b0, '0);
    send_word(cmp, 1'b0, 1'b0, '0);
    for (int i = 0; i < plen; i++) begin
      d = BYTE_W'($urandom_range(0, 255));
      crc = crc16_byte(crc, d);
      send_word(d, 1'b0, 1'b0, '0);
    end
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_word(crc[7:0], 1'b0, 1'b0, '0);
    send_word(crc[15:8], 1'b1, 1'b0, '0);
  endtask

  // Mostly well-formed frames with random content; the rest broken or plain noise.
  task automatic send_random_frame();
    int pick;
    int plen;
    int n;
    logic [BYTE_W-1:0] num;
    pick = $urandom_range(0, 99);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    if (pick < 60) begin
      send_frame(next_block, ~next_block, plen, $urandom_range(0, 9) == 0);
    end else if (pick < 70) begin
      num = next_block - 8'd1;
      send_frame(num, ~num, plen, 1'b0);
    end else if (pick < 78) begin
      num = BYTE_W'($urandom_range(0, 255));
      send_frame(num, ~num, plen, 1'b0);
    end else if (pick < 85) begin
      num = next_block;
      send_frame(num, ~num ^ (8'h01 << $urandom_range(0, 7)), plen, 1'b0);
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send_word(BYTE_W'($urandom_range(0, 255)), i == n - 1, 1'b0, '0);
      end
    end
  endtask

  task automatic send_random(input int n);
    int first;
    first = words_sent;
    while (words_sent - first < n) begin
      send_random_frame();
    end
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_block(input logic [BYTE_W-1:0] v);
    start_block_we <= 1'b1;
    start_block <= v;
    @(posedge clk);
    start_block_we <= 1'b0;
    next_block = v;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Receiver pacing: long hold on request, short random bursts otherwise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      stall_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin : result_monitor
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got kind %0h", $time, out_kind);
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", want.kind, out_kind);
        check_field("payload_byte", want.pay, payload_byte);
        check_field("verdict", want.verd, verdict);
        check_field("block_number", want.num, block_number);
        check_field("data_length", want.len, data_length);
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("upload_block_receive_checker_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    row_t rows[$];
    clear_frame_state();
    next_block = START_BLOCK_RESET;

    // short frame
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h55, 1'b1, KIND_VERDICT, 8'h00, VERD_REJECT, 8'h55, 11'd0));
    // empty payload, number matches the reset value, CRC of nothing is zero
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'hFE, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b1, KIND_VERDICT, 8'h00, VERD_ACCEPT, 8'h01, 11'd0));
    // repeat of block 1 carrying extreme payload bytes: duplicate
    rows.push_back(mk_row(8'hFF, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'hFE, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'hFF, 1'b0, KIND_PAYLOAD, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b0, KIND_PAYLOAD, 8'hFF, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b1, KIND_VERDICT, 8'h00, VERD_DUPLICATE, 8'h01, 11'd2));
    // bad complement
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h02, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h02, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b1, KIND_VERDICT, 8'h00, VERD_REJECT, 8'h02, 11'd0));
    // wrong block number
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h07, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'hF8, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h00, 1'b1, KIND_VERDICT, 8'h00, VERD_REJECT, 8'h07, 11'd0));
    // CRC mismatch on the expected block
    rows.push_back(mk_row(8'h01, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h02, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'hFD, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h12, 1'b0, KIND_NONE, 8'h00, 2'd0, 8'h00, 11'd0));
    rows.push_back(mk_row(8'h34, 1'b1, KIND_VERDICT, 8'h00, VERD_REJECT, 8'h02, 11'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on <= 1'b1;

    foreach (rows[i]) begin
      send_word(rows[i].b, rows[i].l, 1'b1, rows[i].r);
    end
    drain_results();

    // top value: an accepted block wraps the expected number to zero
    write_start_block(8'hFF);
    send_random(200);
    drain_results();

    // zero: no duplicate possible; the receiver holds off while words keep coming
    write_start_block(8'h00);
    hold_ask <= hold_ask + 1;
    send_random(200);
    drain_results();

    write_start_block(8'hFE);
    idle_on <= 1'b0;
    send_random(320);
    drain_results();

    if (errors == 0) begin
      $display("upload_block_receive_checker_core regression: pass");
    end else begin
      $display("upload_block_receive_checker_core regression: fail");
    end
    $finish;
  end

endmodule
